// File: sv/pidpc_pkg.sv
package pidpc_pkg;

  // field widths
  localparam int POS_W   = 16;
  localparam int ERR_W   = POS_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int SUM_W   = 48;
  localparam int GAIN_W  = 32;
  localparam int BAND_W  = 16;
  localparam int LIM_W   = 15;
  localparam int DRIVE_W = 16;

  // integral product is split into two narrower multiplies
  localparam int SUM_SPLIT = 24;
  localparam int SUM_HI_W  = SUM_W - SUM_SPLIT;

  // product widths (gains are unsigned, so one extra sign bit)
  localparam int PROD_P_W  = GAIN_W + 1 + ERR_W;
  localparam int PROD_D_W  = GAIN_W + 1 + DIFF_W;
  localparam int PROD_IL_W = GAIN_W + SUM_SPLIT;
  localparam int PROD_IH_W = GAIN_W + 1 + SUM_HI_W;

  // accumulator holds the exact sum of all terms with headroom
  localparam int ACC_W = GAIN_W + SUM_W + 3;

  // register reset values
  localparam logic [GAIN_W-1:0] GAIN_P_RST      = 32'd80530637;
  localparam logic [GAIN_W-1:0] GAIN_I_RST      = 32'd8;
  localparam logic [GAIN_W-1:0] GAIN_D_RST      = 32'd362387866;
  localparam logic [BAND_W-1:0] DONE_BAND_RST   = 16'd5;
  localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = 15'd200;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P      = 3'd0,
    REG_GAIN_I      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_DONE_BAND   = 3'd3,
    REG_DRIVE_LIMIT = 3'd4
  } pidpc_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [BAND_W-1:0] done_band;
    logic [LIM_W-1:0]  drive_limit;
  } pidpc_cfg_t;

  // error stage result
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIFF_W-1:0] diff;
    logic                     done;
  } pidpc_err_t;

  // product stage result
  typedef struct packed {
    logic signed [PROD_P_W-1:0]  prod_p;
    logic signed [PROD_D_W-1:0]  prod_d;
    logic        [PROD_IL_W-1:0] prod_il;
    logic signed [PROD_IH_W-1:0] prod_ih;
    logic signed [ERR_W-1:0]     err;
    logic                        done;
  } pidpc_prod_t;

  // accumulate stage result
  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [ERR_W-1:0] err;
    logic                    done;
  } pidpc_acc_t;

  // final result
  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic signed [ERR_W-1:0]   err;
    logic                      done;
  } pidpc_res_t;

endpackage

// File: sv/pidpc_error.sv
module pidpc_error (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pidpc_pkg::pidpc_cfg_t         cfg,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [15:0]            setpoint,
  input  logic signed [15:0]            measured,
  input  logic                          restart,
  output logic                          down_valid,
  input  logic                          down_ready,
  output pidpc_pkg::pidpc_err_t         down_data
);
  import pidpc_pkg::*;

  localparam logic signed [SUM_W:0] SUM_MAX = {2'b00, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SUM_MIN = {2'b11, {(SUM_W-1){1'b0}}};

  logic                     valid_r;
  pidpc_err_t               data_r;
  pidpc_err_t               data_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [ERR_W-1:0]  prev_r;
  logic                     primed_r;
  logic signed [SUM_W-1:0]  base_sum;
  logic signed [ERR_W-1:0]  base_prev;
  logic                     base_primed;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_ext;
  logic        [ERR_W-1:0]  err_mag;
  logic                     take;

  assign up_ready = !valid_r || down_ready;
  assign take     = up_valid && up_ready;

  // restart starts from a cleared history
  assign base_sum    = restart ? '0 : sum_r;
  assign base_prev   = restart ? '0 : prev_r;
  assign base_primed = restart ? 1'b0 : primed_r;

  // error, saturating sum, derivative difference and on-target check
  always_comb begin
    err     = ERR_W'(setpoint) - ERR_W'(measured);
    sum_ext = (SUM_W+1)'(base_sum) + (SUM_W+1)'(err);
    data_nxt.err = err;
    if (sum_ext > SUM_MAX) begin
      data_nxt.sum = SUM_W'(SUM_MAX);
    end else if (sum_ext < SUM_MIN) begin
      data_nxt.sum = SUM_W'(SUM_MIN);
    end else begin
      data_nxt.sum = sum_ext[SUM_W-1:0];
    end
    if (base_primed) begin
      data_nxt.diff = DIFF_W'(err) - DIFF_W'(base_prev);
    end else begin
      data_nxt.diff = '0;
    end
    err_mag       = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    data_nxt.done = (err_mag <= {1'b0, cfg.done_band});
  end

  // controller history, updated on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      prev_r   <= '0;
      primed_r <= 1'b0;
    end else if (take) begin
      sum_r    <= data_nxt.sum;
      prev_r   <= err;
      primed_r <= 1'b1;
    end
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign down_valid = valid_r;
  assign down_data  = data_r;

endmodule

// File: sv/pidpc_mult.sv
module pidpc_mult (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pidpc_pkg::pidpc_cfg_t  cfg,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  pidpc_pkg::pidpc_err_t  up_data,
  output logic                   down_valid,
  input  logic                   down_ready,
  output pidpc_pkg::pidpc_prod_t down_data
);
  import pidpc_pkg::*;

  logic        valid_r;
  pidpc_prod_t data_r;
  pidpc_prod_t data_nxt;
  logic        take;

  assign up_ready = !valid_r || down_ready;
  assign take     = up_valid && up_ready;

  // four independent multiplies; integral term split at SUM_SPLIT
  always_comb begin
    data_nxt.prod_p  = $signed({1'b0, cfg.gain_p}) * $signed(up_data.err);
    data_nxt.prod_d  = $signed({1'b0, cfg.gain_d}) * $signed(up_data.diff);
    data_nxt.prod_il = cfg.gain_i * up_data.sum[SUM_SPLIT-1:0];
    data_nxt.prod_ih = $signed({1'b0, cfg.gain_i}) * $signed(up_data.sum[SUM_W-1:SUM_SPLIT]);
    data_nxt.err     = up_data.err;
    data_nxt.done    = up_data.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign down_valid = valid_r;
  assign down_data  = data_r;

endmodule

// File: sv/pidpc_accum.sv
module pidpc_accum (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  pidpc_pkg::pidpc_prod_t up_data,
  output logic                   down_valid,
  input  logic                   down_ready,
  output pidpc_pkg::pidpc_acc_t  down_data
);
  import pidpc_pkg::*;

  logic                    valid_r;
  pidpc_acc_t              data_r;
  pidpc_acc_t              data_nxt;
  logic signed [ACC_W-1:0] term_ih;
  logic                    take;

  assign up_ready = !valid_r || down_ready;
  assign take     = up_valid && up_ready;

  // exact sum of the p, i and d terms
  always_comb begin
    term_ih      = ACC_W'(up_data.prod_ih) <<< SUM_SPLIT;
    data_nxt.acc = ACC_W'(up_data.prod_p) + ACC_W'(up_data.prod_d)
                 + $signed(ACC_W'(up_data.prod_il)) + term_ih;
    data_nxt.err  = up_data.err;
    data_nxt.done = up_data.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign down_valid = valid_r;
  assign down_data  = data_r;

endmodule

// File: sv/pidpc_limit.sv
module pidpc_limit #(
  parameter int GAIN_FRAC_BITS = 28
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pidpc_pkg::pidpc_cfg_t  cfg,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  pidpc_pkg::pidpc_acc_t  up_data,
  output logic                   down_valid,
  input  logic                   down_ready,
  output pidpc_pkg::pidpc_res_t  down_data
);
  import pidpc_pkg::*;

  logic                    valid_r;
  pidpc_res_t              data_r;
  pidpc_res_t              data_nxt;
  logic signed [ACC_W-1:0] shifted;
  logic signed [ACC_W-1:0] lim_pos;
  logic signed [ACC_W-1:0] lim_neg;
  logic                    take;

  assign up_ready = !valid_r || down_ready;
  assign take     = up_valid && up_ready;

  // scale down (floor) and clamp to the drive limit
  always_comb begin
    shifted = up_data.acc >>> GAIN_FRAC_BITS;
    lim_pos = $signed(ACC_W'(cfg.drive_limit));
    lim_neg = -lim_pos;
    if (shifted > lim_pos) begin
      data_nxt.drive = DRIVE_W'(lim_pos);
    end else if (shifted < lim_neg) begin
      data_nxt.drive = DRIVE_W'(lim_neg);
    end else begin
      data_nxt.drive = DRIVE_W'(shifted);
    end
    data_nxt.err  = up_data.err;
    data_nxt.done = up_data.done;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign down_valid = valid_r;
  assign down_data  = data_r;

endmodule

// File: sv/pid_position_controller.sv
// channel   | direction | tdata (low bit up)                        | tuser
// ----------+-----------+-------------------------------------------+---------
// in_       | slave     | setpoint[15:0], measured[31:16]           | restart
// out_      | master    | drive[15:0], error_value[32:16], 0 pad     | done_res
// cfg_      | write     | cfg_index selects register, cfg_wdata     | -
//
// one item per clock while out_ is not stalled; a result passes the error,
// product, accumulate and limit registers in sequence after its input transfer.
// each stage holds one item and takes a new one when it is empty or its
// successor takes its item, so stalls on out_ back up stage by stage.
// rst_n (synchronous) clears stage valids, the error history and loads
// the register defaults.
module pid_position_controller #(
  parameter int GAIN_FRAC_BITS = 28
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [31:0]                         in_tdata,  // setpoint, measured
  input  logic                                in_tuser,  // restart
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [39:0]                         out_tdata, // drive, error_value, pad
  output logic                                out_tuser, // done_res
  input  logic                                cfg_we,
  input  logic [pidpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import pidpc_pkg::*;

  pidpc_cfg_t  cfg_r;
  logic        err_valid;
  logic        err_ready;
  pidpc_err_t  err_data;
  logic        prod_valid;
  logic        prod_ready;
  pidpc_prod_t prod_data;
  logic        acc_valid;
  logic        acc_ready;
  pidpc_acc_t  acc_data;
  pidpc_res_t  res_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= GAIN_P_RST;
      cfg_r.gain_i      <= GAIN_I_RST;
      cfg_r.gain_d      <= GAIN_D_RST;
      cfg_r.done_band   <= DONE_BAND_RST;
      cfg_r.drive_limit <= DRIVE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (pidpc_reg_t'(cfg_index))
        REG_GAIN_P:      cfg_r.gain_p      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:      cfg_r.gain_i      <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:      cfg_r.gain_d      <= cfg_wdata[GAIN_W-1:0];
        REG_DONE_BAND:   cfg_r.done_band   <= cfg_wdata[BAND_W-1:0];
        REG_DRIVE_LIMIT: cfg_r.drive_limit <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // error and history
  pidpc_error u_error (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .setpoint   ($signed(in_tdata[15:0])),
    .measured   ($signed(in_tdata[31:16])),
    .restart    (in_tuser),
    .down_valid (err_valid),
    .down_ready (err_ready),
    .down_data  (err_data)
  );

  // gain products
  pidpc_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_valid   (err_valid),
    .up_ready   (err_ready),
    .up_data    (err_data),
    .down_valid (prod_valid),
    .down_ready (prod_ready),
    .down_data  (prod_data)
  );

  // term sum
  pidpc_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (prod_valid),
    .up_ready   (prod_ready),
    .up_data    (prod_data),
    .down_valid (acc_valid),
    .down_ready (acc_ready),
    .down_data  (acc_data)
  );

  // scale, clamp and output register
  pidpc_limit #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_limit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_valid   (acc_valid),
    .up_ready   (acc_ready),
    .up_data    (acc_data),
    .down_valid (out_tvalid),
    .down_ready (out_tready),
    .down_data  (res_data)
  );

  assign out_tdata = {7'd0, res_data.err, res_data.drive};
  assign out_tuser = res_data.done;

  // checks on the result
  logic signed [DRIVE_W-1:0] chk_lim;
  logic        [ERR_W-1:0]   chk_mag;

  assign chk_lim = $signed(DRIVE_W'(cfg_r.drive_limit));
  assign chk_mag = res_data.err[ERR_W-1] ? ERR_W'(-res_data.err) : ERR_W'(res_data.err);

  // drive never leaves the configured limit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res_data.drive <= chk_lim) && (res_data.drive >= -chk_lim))
    else $error("drive outside limit");

  // done flag agrees with the error carried alongside it
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == (chk_mag <= {1'b0, cfg_r.done_band})))
    else $error("done flag does not match error");

  // input backs off only when the output is full and stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output stall");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import pidpc_pkg::*;

  localparam int FRAC_BITS    = 28;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AT      = 250;
  localparam int STEADY_FROM  = 700;
  localparam int STEADY_TO    = 850;
  localparam int IDLE_PCT     = 31;
  localparam int MAX_REPORTS  = 10;

  // index outside the register map, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam logic signed [48:0] SUM_MAX = 49'sh7FFF_FFFF_FFFF;
  localparam logic signed [48:0] SUM_MIN = -49'sh7FFF_FFFF_FFFF - 49'sd1;

  typedef struct {
    logic signed [POS_W-1:0] setpoint;
    logic signed [POS_W-1:0] measured;
    logic                    restart;
  } sample_t;

  typedef struct {
    logic signed [DRIVE_W-1:0] drive;
    logic                      done;
    logic signed [ERR_W-1:0]   err;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [31:0]           in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [39:0]           out_tdata;
  logic                  out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // controller settings as the block should hold them
  logic [GAIN_W-1:0] kp = GAIN_P_RST;
  logic [GAIN_W-1:0] ki = GAIN_I_RST;
  logic [GAIN_W-1:0] kd = GAIN_D_RST;
  logic [BAND_W-1:0] band = DONE_BAND_RST;
  logic [LIM_W-1:0]  drive_lim = DRIVE_LIMIT_RST;

  // loop state mirrored from the block
  logic signed [SUM_W-1:0] integ_sum = '0;
  logic signed [ERR_W-1:0] last_err = '0;
  logic                    have_last = 1'b0;

  sample_t       pending_samples[$];
  drive_result_t drive_expect[$];

  logic in_fire = 1'b0;
  logic steady;
  int   accepted_items = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   restarts = 0;
  int   clamped = 0;
  int   in_band = 0;
  int   settings = 1;
  int   stall_cycles = 0;
  int   hold_left = 0;
  bit   hold_taken = 1'b0;

  // random sample generator state
  logic signed [POS_W-1:0] track_sp = '0;
  int                      track_ms = 0;

  pid_position_controller #(
    .GAIN_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  assign steady = accepted_items >= STEADY_FROM && accepted_items < STEADY_TO;

  // one control step: error, saturating integral, derivative, limited drive
  function automatic drive_result_t predict_drive(sample_t s);
    logic signed [ERR_W-1:0] e;
    logic signed [48:0]      sum_wide;
    logic signed [17:0]      diff;
    logic signed [127:0]     acc;
    logic signed [127:0]     shifted;
    logic signed [127:0]     lim_pos;
    logic signed [127:0]     lim_neg;
    int                      abs_e;
    drive_result_t           r;
    if (s.restart) begin
      integ_sum = '0;
      last_err = '0;
      have_last = 1'b0;
      restarts++;
    end
    e = s.setpoint - s.measured;
    sum_wide = integ_sum + e;
    if (sum_wide > SUM_MAX) begin
      sum_wide = SUM_MAX;
    end else if (sum_wide < SUM_MIN) begin
      sum_wide = SUM_MIN;
    end
    integ_sum = sum_wide[SUM_W-1:0];
    // no derivative kick on the first sample after a restart
    diff = have_last ? e - last_err : 18'sd0;
    last_err = e;
    have_last = 1'b1;
    acc = $signed({96'b0, kp}) * e + $signed({96'b0, ki}) * integ_sum
        + $signed({96'b0, kd}) * diff;
    shifted = acc >>> FRAC_BITS;
    lim_pos = $signed({113'b0, drive_lim});
    lim_neg = -lim_pos;
    if (shifted > lim_pos) begin
      r.drive = lim_pos[DRIVE_W-1:0];
      clamped++;
    end else if (shifted < lim_neg) begin
      r.drive = lim_neg[DRIVE_W-1:0];
      clamped++;
    end else begin
      r.drive = shifted[DRIVE_W-1:0];
    end
    abs_e = (e < 0) ? -int'(e) : int'(e);
    r.done = abs_e <= int'(band);
    r.err = e;
    return r;
  endfunction

  // sender: new item at the falling edge once the last one is taken
  always @(negedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        s = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {s.measured, s.setpoint};
        in_tuser <= s.restart;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random backpressure plus one long hold-off
  always @(negedge clk) begin
    if (!hold_taken && results_seen >= HOLD_AT) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // predict on input transfers, check on output transfers
  always @(posedge clk) begin
    sample_t       s;
    drive_result_t got;
    drive_result_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      s.setpoint = in_tdata[15:0];
      s.measured = in_tdata[31:16];
      s.restart = in_tuser;
      drive_expect.push_back(predict_drive(s));
      accepted_items++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.drive = out_tdata[15:0];
      got.err = out_tdata[32:16];
      got.done = out_tuser;
      results_seen++;
      if (drive_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result %0d: drive %0d done %0b error %0d",
                   results_seen, got.drive, got.done, got.err);
        end
      end else begin
        want = drive_expect.pop_front();
        if (want.done) in_band++;
        if (got.drive !== want.drive || got.done !== want.done || got.err !== want.err) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d: drive exp %0d got %0d, done exp %0b got %0b, error exp %0d got %0d",
                     results_seen, want.drive, got.drive, want.done, got.done,
                     want.err, got.err);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results outstanding",
               stall_cycles, drive_expect.size());
      $display("** pid_position_controller: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_sample(logic signed [POS_W-1:0] sp, logic signed [POS_W-1:0] ms,
                             logic rs);
    sample_t s;
    s.setpoint = sp;
    s.measured = ms;
    s.restart = rs;
    pending_samples.push_back(s);
  endtask

  // mostly a plant tracking its target, some restarts and raw noise
  task automatic push_random(int count);
    sample_t s;
    int      pick;
    int      step;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        s.setpoint = 16'($urandom);
        s.measured = 16'($urandom);
        s.restart = 1'($urandom_range(1));
      end else begin
        s.restart = pick < 15;
        if (pick < 22) track_sp = 16'($urandom);
        step = (int'(track_sp) - track_ms) / int'($urandom_range(1, 4))
             + int'($urandom_range(16)) - 8;
        track_ms = track_ms + step;
        if (track_ms > 32767) track_ms = 32767;
        if (track_ms < -32768) track_ms = -32768;
        s.setpoint = track_sp;
        s.measured = 16'(track_ms);
      end
      pending_samples.push_back(s);
    end
  endtask

  // all offered, all results back, pipeline drained
  task automatic wait_idle();
    while (pending_samples.size() > 0 || in_tvalid || drive_expect.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      REG_GAIN_P:      kp = value;
      REG_GAIN_I:      ki = value;
      REG_GAIN_D:      kd = value;
      REG_DONE_BAND:   band = value[BAND_W-1:0];
      REG_DRIVE_LIMIT: drive_lim = value[LIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_settings(logic [GAIN_W-1:0] gp, logic [GAIN_W-1:0] gi,
                               logic [GAIN_W-1:0] gd, logic [BAND_W-1:0] bd,
                               logic [LIM_W-1:0] lim);
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_DONE_BAND, {16'b0, bd});
    write_reg(REG_DRIVE_LIMIT, {17'b0, lim});
    settings++;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset gains: first sample, derivative step, done band edges, extremes
    push_sample(16'sd0, 16'sd0, 1'b1);
    push_sample(16'sd100, 16'sd0, 1'b0);
    push_sample(16'sd100, 16'sd95, 1'b0);
    push_sample(16'sd100, 16'sd94, 1'b0);
    push_sample(-16'sd100, -16'sd95, 1'b0);
    push_sample(-16'sd100, -16'sd94, 1'b0);
    push_sample(16'sh7FFF, 16'sh8000, 1'b0);
    push_sample(16'sh8000, 16'sh7FFF, 1'b0);
    push_sample(16'sh7FFF, 16'sh8000, 1'b1);
    push_sample(16'sh8000, 16'sh8000, 1'b0);
    push_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
    push_sample(-16'sd1, 16'sd0, 1'b0);
    push_sample(16'sd0, -16'sd1, 1'b0);
    push_sample(16'sh5555, 16'shAAAA, 1'b0);
    push_sample(16'shAAAA, 16'sh5555, 1'b1);
    push_random(160);
    wait_idle();

    // largest gains, band and limit
    load_settings('1, '1, '1, '1, '1);
    push_sample(16'sh7FFF, 16'sh8000, 1'b1);
    push_sample(16'sh8000, 16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 16'sh7FFF, 1'b0);
    push_sample(16'sd0, 16'sd0, 1'b0);
    push_random(160);
    wait_idle();

    // everything zero: drive forced to zero, only exact target is done
    load_settings('0, '0, '0, '0, '0);
    push_sample(16'sd0, 16'sd0, 1'b1);
    push_sample(16'sd1, 16'sd0, 1'b0);
    push_sample(16'sh7FFF, 16'sh8000, 1'b0);
    push_random(120);
    wait_idle();

    // random moderate tuning, then a write to an unmapped index
    load_settings(GAIN_W'($urandom_range(0, 32'h2000_0000)),
                  GAIN_W'($urandom_range(0, 32'h0010_0000)),
                  GAIN_W'($urandom_range(0, 32'h4000_0000)),
                  BAND_W'($urandom_range(0, 200)), LIM_W'($urandom_range(1, 32767)));
    write_reg(REG_UNMAPPED, 32'hDEAD_BEEF);
    push_random(170);
    wait_idle();

    // small gains, widest limit
    load_settings(GAIN_W'($urandom_range(0, 32'h0100_0000)),
                  GAIN_W'($urandom_range(0, 32'h0000_1000)),
                  GAIN_W'($urandom_range(0, 32'h0400_0000)),
                  BAND_W'($urandom_range(0, 50)), 15'h7FFF);
    push_random(180);
    wait_idle();

    // fully random settings
    load_settings(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                  BAND_W'($urandom), LIM_W'($urandom));
    push_random(180);
    wait_idle();

    // back to the reset tuning
    load_settings(GAIN_P_RST, GAIN_I_RST, GAIN_D_RST, DONE_BAND_RST, DRIVE_LIMIT_RST);
    push_random(160);
    wait_idle();

    $display("ran %0d samples (%0d restarts) through %0d controller settings",
             accepted_items, restarts, settings);
    $display("checked %0d results: %0d at the drive limit, %0d inside the done band",
             results_seen, clamped, in_band);
    if (mismatches == 0 && drive_expect.size() == 0) begin
      $display("** pid_position_controller: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** pid_position_controller: FAILED **");
    end
    $finish;
  end

endmodule
